// ----- hdl/execute_operand_forwarding_assert.svh -----
// Assertion macros shared by the execute operand forwarding RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef EXECUTE_OPERAND_FORWARDING_ASSERT_SVH
`define EXECUTE_OPERAND_FORWARDING_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define EXOFWD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define EXOFWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/exofwd_pkg.sv -----
// Types, codes and constants for the execute operand forwarding block.
// No dependencies; imported by every module of the block.
package exofwd_pkg;

  localparam logic [3:0] R_PC = 4'd15;

  localparam int CTRL_USE_RM     = 0;
  localparam int CTRL_USE_RS     = 1;
  localparam int CTRL_MEM_WR     = 2;
  localparam int CTRL_MEM_WB     = 3;
  localparam int CTRL_IRQ        = 4;
  localparam int CTRL_BLOCK      = 5;
  localparam int CTRL_LOAD_STORE = 6;
  localparam int CTRL_BASE_WB    = 7;
  localparam int CTRL_COMPARE    = 8;

  typedef enum logic [3:0] {
    COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
    COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
  } cond_t;

  typedef struct packed {
    logic [3:0]  cond_code;
    logic [3:0]  nzcv;
    logic [15:0] reg_numbers;
    logic [31:0] value_n;
    logic [31:0] value_m;
    logic [31:0] value_s;
    logic [31:0] prev_result;
    logic [3:0]  mem_dest;
    logic [3:0]  mem_base;
    logic [31:0] mem_value;
    logic [8:0]  ctrl_bits;
  } exofwd_in_t;

  typedef struct packed {
    logic [31:0] operand_n;
    logic [31:0] operand_m;
    logic [31:0] operand_s;
    logic        cond_pass;
    logic        executed;
    logic        hold;
  } exofwd_out_t;

  typedef struct packed {
    logic       executed;
    logic       load_store;
    logic       compare;
    logic [3:0] dest;
    logic [3:0] base;
    logic       base_writeback;
    logic       used_rm;
    logic       used_rs;
  } exofwd_last_t;

endpackage

// ----- hdl/exofwd_cond.sv -----
// Condition field evaluation against the NZCV flags.
// Depends on exofwd_pkg for the condition codes.
module exofwd_cond import exofwd_pkg::*; (
  input  logic [3:0] cond_code,
  input  logic [3:0] nzcv,
  output logic       cond_pass
);

  logic n, z, c, v;

  assign n = nzcv[3];
  assign z = nzcv[2];
  assign c = nzcv[1];
  assign v = nzcv[0];

  always_comb begin
    case (cond_t'(cond_code))
      COND_EQ: cond_pass = z;
      COND_NE: cond_pass = !z;
      COND_CS: cond_pass = c;
      COND_CC: cond_pass = !c;
      COND_MI: cond_pass = n;
      COND_PL: cond_pass = !n;
      COND_VS: cond_pass = v;
      COND_VC: cond_pass = !v;
      COND_HI: cond_pass = c && !z;
      COND_LS: cond_pass = !c || z;
      COND_GE: cond_pass = (n == v);
      COND_LT: cond_pass = (n != v);
      COND_GT: cond_pass = !z && (n == v);
      COND_LE: cond_pass = z || (n != v);
      COND_AL: cond_pass = 1'b1;
      COND_NV: cond_pass = 1'b0;
      default: cond_pass = 1'b0;
    endcase
  end

endmodule

// ----- hdl/exofwd_bypass.sv -----
// Operand bypass network for Rn, Rm and Rs from the memory stage and the
// previous execute-stage instruction. Depends on exofwd_pkg.
module exofwd_bypass import exofwd_pkg::*; (
  input  exofwd_in_t   item,
  input  exofwd_last_t last,
  output logic [31:0]  operand_n,
  output logic [31:0]  operand_m,
  output logic [31:0]  operand_s
);

  function automatic logic hit(input logic [3:0] opr, input logic [3:0] wr,
                               input logic en);
    hit = en && (opr != R_PC) && (opr == wr);
  endfunction

  logic [3:0] rn, rm, rs;
  logic       mem_on, mem_wr, mem_wb, ex_dest, ex_base;
  logic       use_m, use_s, ex_use_m, ex_use_s;

  assign rn       = item.reg_numbers[11:8];
  assign rm       = item.reg_numbers[7:4];
  assign rs       = item.reg_numbers[3:0];
  assign mem_on   = (item.mem_dest != R_PC);
  assign mem_wr   = mem_on && item.ctrl_bits[CTRL_MEM_WR];
  assign mem_wb   = mem_on && item.ctrl_bits[CTRL_MEM_WB];
  assign ex_dest  = last.executed && !last.load_store && !last.compare;
  assign ex_base  = last.executed && last.base_writeback;
  assign use_m    = item.ctrl_bits[CTRL_USE_RM];
  assign use_s    = item.ctrl_bits[CTRL_USE_RS];
  assign ex_use_m = use_m && last.used_rm;
  assign ex_use_s = use_s && last.used_rs;

  // The newer execute-stage result is applied last so that it wins.
  always_comb begin
    operand_n = item.value_n;
    if (mem_wr && hit(rn, item.mem_dest, 1'b1)) operand_n = item.mem_value;
    if (mem_wb && hit(rn, item.mem_base, 1'b1)) operand_n = item.mem_value;
    if (ex_dest && hit(rn, last.dest, 1'b1)) operand_n = item.prev_result;
    if (ex_base && hit(rn, last.base, 1'b1)) operand_n = item.prev_result;

    operand_m = item.value_m;
    if (mem_wr && hit(rm, item.mem_dest, use_m)) operand_m = item.mem_value;
    if (mem_wb && hit(rm, item.mem_base, use_m)) operand_m = item.mem_value;
    if (ex_dest && hit(rm, last.dest, ex_use_m)) operand_m = item.prev_result;
    if (ex_base && hit(rm, last.base, ex_use_m)) operand_m = item.prev_result;

    operand_s = item.value_s;
    if (mem_wr && hit(rs, item.mem_dest, use_s)) operand_s = item.mem_value;
    if (mem_wb && hit(rs, item.mem_base, use_s)) operand_s = item.mem_value;
    if (ex_dest && hit(rs, last.dest, ex_use_s)) operand_s = item.prev_result;
    if (ex_base && hit(rs, last.base, ex_use_s)) operand_s = item.prev_result;
  end

endmodule

// ----- hdl/execute_operand_forwarding.sv -----
// A beat accepted into the input register moves on to the result register and is
// presented from there. Throughput: one beat per cycle while the output is not stalled;
// while a result waits, one further beat is still taken into the input register.
// Reset (synchronous, active low) empties both registers and sets the
// instruction history to a non-executed compare, so nothing is forwarded.
module execute_operand_forwarding import exofwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  exofwd_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output exofwd_out_t out_data
);

`include "execute_operand_forwarding_assert.svh"

  exofwd_in_t   s1_r;
  logic         s1_valid_r, s1_valid_nxt;
  exofwd_out_t  out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;
  exofwd_last_t last_r, last_nxt;
  logic         in_take, advance, cond_pass, exe, record;
  logic [31:0]  op_n, op_m, op_s;

  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);

  exofwd_cond u_cond (
    .cond_code (s1_r.cond_code),
    .nzcv      (s1_r.nzcv),
    .cond_pass (cond_pass)
  );

  exofwd_bypass u_bypass (
    .item      (s1_r),
    .last      (last_r),
    .operand_n (op_n),
    .operand_m (op_m),
    .operand_s (op_s)
  );

  assign exe    = cond_pass && !s1_r.ctrl_bits[CTRL_IRQ];
  assign record = advance && (exe || (s1_r.reg_numbers[15:12] == R_PC));

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);

    out_nxt.operand_n = op_n;
    out_nxt.operand_m = op_m;
    out_nxt.operand_s = op_s;
    out_nxt.cond_pass = cond_pass;
    out_nxt.executed  = exe;
    out_nxt.hold      = exe && s1_r.ctrl_bits[CTRL_BLOCK];

    last_nxt = last_r;
    if (record) begin
      last_nxt.executed       = exe;
      last_nxt.load_store     = s1_r.ctrl_bits[CTRL_LOAD_STORE];
      last_nxt.compare        = s1_r.ctrl_bits[CTRL_COMPARE];
      last_nxt.dest           = s1_r.reg_numbers[15:12];
      last_nxt.base           = s1_r.reg_numbers[11:8];
      last_nxt.base_writeback = s1_r.ctrl_bits[CTRL_BASE_WB];
      last_nxt.used_rm        = s1_r.ctrl_bits[CTRL_USE_RM];
      last_nxt.used_rs        = s1_r.ctrl_bits[CTRL_USE_RS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= '{executed: 1'b0, load_store: 1'b0, compare: 1'b1,
                       dest: 4'd0, base: 4'd0, base_writeback: 1'b0,
                       used_rm: 1'b0, used_rs: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `EXOFWD_ASSERT_ALWAYS(a_hold_needs_exec, !out_valid_r || !out_r.hold || out_r.executed, "hold raised for a beat that did not execute")
  `EXOFWD_ASSERT_ALWAYS(a_exec_needs_pass, !out_valid_r || !out_r.executed || out_r.cond_pass, "executed without the condition passing")
  `EXOFWD_ASSERT_NEXT(a_history_dest, record, last_r.dest == $past(s1_r.reg_numbers[15:12]), "history destination not recorded")

endmodule
